[sv/sops_pkg.sv]
// shared types, register indexes and datapath command codes for the position shaper
package sops_pkg;

    localparam int TIME_FRAC_BITS = 24;
    localparam int VEL_MAG_BITS   = 24;
    localparam int DIV_STEPS      = TIME_FRAC_BITS + VEL_MAG_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

    // 2*pi in Q24
    localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;

    localparam logic [2:0] CFG_NAT_FREQ  = 3'd0;
    localparam logic [2:0] CFG_DAMPING   = 3'd1;
    localparam logic [2:0] CFG_VEL_LIMIT = 3'd2;
    localparam logic [2:0] CFG_ACC_LIMIT = 3'd3;
    localparam logic [2:0] CFG_POS_FLOOR = 3'd4;
    localparam logic [2:0] CFG_POS_CEIL  = 3'd5;

    localparam logic ACT_RESET = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [23:0] position_in;
        logic signed [23:0] velocity_in;
        logic [23:0]        time_step;
    } sops_in_t;

    typedef struct packed {
        logic signed [23:0] ref_position;
        logic signed [23:0] ref_velocity;
        logic signed [31:0] ref_acceleration;
        logic               is_initialized;
    } sops_out_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_OMEGA,
        OP_SET_OMEGA,
        OP_MUL_W2,
        OP_SET_W2,
        OP_MUL_ZW,
        OP_SET_ZW,
        OP_MUL_WLO,
        OP_ACC_LOAD,
        OP_MUL_WHI,
        OP_ACC_ADD19,
        OP_MUL_ZV,
        OP_ACC_SUB1,
        OP_SET_ACC,
        OP_MUL_DTA,
        OP_SET_VEL,
        OP_MUL_DTV,
        OP_SET_POS,
        OP_DIV_START,
        OP_COMMIT_RESET,
        OP_COMMIT_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_step;
        logic step_go;
        logic div_busy;
    } dp_status_t;

endpackage

[sv/second_order_position_shaper.sv]
// top level of the second-order position shaper
//
// input channel s_*: one item carries an action (reset from measurement or step),
// a position, a velocity and a step interval. result channel m_*: one item per
// input item with reference position, velocity, acceleration and the init flag.
// configuration: cfg_we with cfg_index and cfg_wdata writes one register per
// cycle; write only while no item is in flight.
// timing: a reset item, or a step that does not update, goes from acceptance
// through the decide state to its commit state. an updating step passes the
// decide state, the shared multiplier and accumulator steps, the divider start,
// the one-bit-per-cycle divider that forms the output acceleration and the wait
// for it to finish, then commits and presents the result.
// one item is worked on at a time; s_ready is high only while the sequencer
// is idle. a finished result sits in the held-state register while the next
// item is taken and computed; that item waits at its commit step while m_valid
// is high and m_ready is low.
// reset: synchronous, active low; restores the register defaults, clears the
// held state and the init flag, and drops m_valid.
module second_order_position_shaper
    import sops_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sops_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output sops_out_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sops_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sops_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_item   (s_data),
        .cmd       (cmd),
        .status    (status),
        .out_item  (m_data)
    );

endmodule

[sv/sops_div.sv]
// restoring divider, one quotient bit per cycle, unsigned magnitudes
module sops_div
    import sops_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VEL_MAG_BITS-1:0] dividend_mag,
    input  logic [23:0]            divisor,
    output logic                   busy,
    output logic [DIV_STEPS-1:0]   quotient
);

    logic                    busy_reg, busy_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_STEPS-1:0]    num_reg, num_next;
    logic [23:0]             rem_reg, rem_next;
    logic [24:0]             trial;
    logic [24:0]             diff;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, num_reg[DIV_STEPS-1]};
        diff      = trial - {1'b0, divisor};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIV_STEPS - 1);
            num_next  = {dividend_mag, {TIME_FRAC_BITS{1'b0}}};
            rem_next  = '0;
        end else if (busy_reg) begin
            if (!diff[24]) begin
                rem_next = diff[23:0];
                num_next = {num_reg[DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_next = trial[23:0];
                num_next = {num_reg[DIV_STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

[sv/sops_dp.sv]
// datapath: configuration, held state, shared multiplier, accumulator and divider
module sops_dp
    import sops_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_wdata,
    input  sops_in_t    in_item,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output sops_out_t   out_item
);

    logic [15:0]        nf_reg, dr_reg;
    logic [22:0]        vlim_reg;
    logic [30:0]        alim_reg;
    logic signed [23:0] pfloor_reg, pceil_reg;

    logic               act_reg;
    logic signed [23:0] pin_reg, vin_reg;
    logic [23:0]        dt_reg;
    logic signed [24:0] diff_reg;

    logic signed [23:0] pos_reg, vel_reg;
    logic signed [31:0] accel_reg;
    logic               flag_reg;

    logic [26:0]        omega_reg;
    logic [37:0]        w2_reg;
    logic [30:0]        zw_reg;
    logic signed [60:0] prod_reg;
    logic signed [63:0] accum_reg;
    logic signed [31:0] acccl_reg;
    logic signed [23:0] vnew_reg, pnew_reg;
    logic               dneg_reg;

    logic signed [32:0] mul_a;
    logic signed [27:0] mul_b;
    logic signed [60:0] prod_next;
    logic signed [63:0] prod64, rnd16, rnd12, rnd24, req, vsum, cand;
    logic signed [63:0] amax64, vmax64, floor64, ceil64;
    logic signed [31:0] acc_clamped;
    logic signed [23:0] vel_clamped, pos_clamped, target;
    logic               pos_clipped;
    logic               cfg_valid, reset_ok;
    logic signed [24:0] vdiff;
    logic [23:0]        vdiff_mag;
    logic               div_busy;
    logic [DIV_STEPS-1:0] quot;
    logic signed [31:0] acc_out;

    assign cfg_valid = (nf_reg != '0) && (dr_reg != '0) && (vlim_reg != '0) &&
                       (alim_reg != '0) && (pfloor_reg < pceil_reg);

    assign reset_ok = cfg_valid && (pin_reg >= pfloor_reg) && (pin_reg <= pceil_reg) &&
                      ($signed({vin_reg[23], vin_reg}) <= $signed({2'b00, vlim_reg})) &&
                      ($signed({vin_reg[23], vin_reg}) >= -$signed({2'b00, vlim_reg}));

    // target clamp happens as the item is taken in
    always_comb begin
        if (in_item.position_in < pfloor_reg) begin
            target = pfloor_reg;
        end else if (in_item.position_in > pceil_reg) begin
            target = pceil_reg;
        end else begin
            target = in_item.position_in;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_OMEGA: begin
                mul_a = {17'b0, nf_reg};
                mul_b = {1'b0, TWO_PI_Q24};
            end
            OP_MUL_W2: begin
                mul_a = {6'b0, omega_reg};
                mul_b = {1'b0, omega_reg};
            end
            OP_MUL_ZW: begin
                mul_a = {17'b0, dr_reg};
                mul_b = {1'b0, omega_reg};
            end
            OP_MUL_WLO: begin
                mul_a = {14'b0, w2_reg[18:0]};
                mul_b = {{3{diff_reg[24]}}, diff_reg};
            end
            OP_MUL_WHI: begin
                mul_a = {14'b0, w2_reg[37:19]};
                mul_b = {{3{diff_reg[24]}}, diff_reg};
            end
            OP_MUL_ZV: begin
                mul_a = {2'b0, zw_reg};
                mul_b = {{4{vel_reg[23]}}, vel_reg};
            end
            OP_MUL_DTA: begin
                mul_a = {acccl_reg[31], acccl_reg};
                mul_b = {4'b0, dt_reg};
            end
            OP_MUL_DTV: begin
                mul_a = {{9{vnew_reg[23]}}, vnew_reg};
                mul_b = {4'b0, dt_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // round half up is an add and an arithmetic shift
    always_comb begin
        prod64  = {{3{prod_reg[60]}}, prod_reg};
        rnd16   = (prod64 + 64'sd32768) >>> 16;
        rnd12   = (prod64 + 64'sd2048) >>> 12;
        rnd24   = (prod64 + 64'sd8388608) >>> 24;
        req     = (accum_reg + 64'sd32768) >>> 16;
        amax64  = {33'b0, alim_reg};
        vmax64  = {41'b0, vlim_reg};
        floor64 = {{40{pfloor_reg[23]}}, pfloor_reg};
        ceil64  = {{40{pceil_reg[23]}}, pceil_reg};

        if (req > amax64) begin
            acc_clamped = {1'b0, alim_reg};
        end else if (req < -amax64) begin
            acc_clamped = -$signed({1'b0, alim_reg});
        end else begin
            acc_clamped = req[31:0];
        end

        vsum = {{40{vel_reg[23]}}, vel_reg} + rnd24;
        if (vsum > vmax64) begin
            vel_clamped = {1'b0, vlim_reg};
        end else if (vsum < -vmax64) begin
            vel_clamped = -$signed({1'b0, vlim_reg});
        end else begin
            vel_clamped = vsum[23:0];
        end

        cand        = {{40{pos_reg[23]}}, pos_reg} + rnd24;
        pos_clipped = 1'b1;
        if (cand > ceil64) begin
            pos_clamped = pceil_reg;
        end else if (cand < floor64) begin
            pos_clamped = pfloor_reg;
        end else begin
            pos_clamped = cand[23:0];
            pos_clipped = 1'b0;
        end

        vdiff     = {vnew_reg[23], vnew_reg} - {vel_reg[23], vel_reg};
        vdiff_mag = vdiff[24] ? 24'(-vdiff) : vdiff[23:0];

        // saturate the quotient magnitude back to a signed 32 bit value
        if (!dneg_reg) begin
            acc_out = (quot > DIV_STEPS'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                        : $signed(quot[31:0]);
        end else begin
            acc_out = (quot > DIV_STEPS'(32'h8000_0000)) ? 32'sh8000_0000
                                                        : -$signed(quot[31:0]);
        end
    end

    sops_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (cmd.op == OP_DIV_START),
        .dividend_mag (vdiff_mag),
        .divisor      (dt_reg),
        .busy         (div_busy),
        .quotient     (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nf_reg     <= 16'd256;
            dr_reg     <= 16'd4096;
            vlim_reg   <= 23'd65536;
            alim_reg   <= 31'd655360;
            pfloor_reg <= -24'sd65536;
            pceil_reg  <= 24'sd65536;
            pos_reg    <= '0;
            vel_reg    <= '0;
            accel_reg  <= '0;
            flag_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NAT_FREQ:  nf_reg     <= cfg_wdata[15:0];
                    CFG_DAMPING:   dr_reg     <= cfg_wdata[15:0];
                    CFG_VEL_LIMIT: vlim_reg   <= cfg_wdata[22:0];
                    CFG_ACC_LIMIT: alim_reg   <= cfg_wdata[30:0];
                    CFG_POS_FLOOR: pfloor_reg <= cfg_wdata[23:0];
                    CFG_POS_CEIL:  pceil_reg  <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_COMMIT_RESET: begin
                    if (reset_ok) begin
                        pos_reg  <= pin_reg;
                        vel_reg  <= vin_reg;
                        flag_reg <= 1'b1;
                    end else begin
                        pos_reg  <= '0;
                        vel_reg  <= '0;
                        flag_reg <= 1'b0;
                    end
                    accel_reg <= '0;
                end
                OP_COMMIT_STEP: begin
                    pos_reg   <= pnew_reg;
                    vel_reg   <= vnew_reg;
                    accel_reg <= acc_out;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        case (cmd.op)
            OP_LOAD: begin
                act_reg  <= in_item.action;
                pin_reg  <= in_item.position_in;
                vin_reg  <= in_item.velocity_in;
                dt_reg   <= in_item.time_step;
                diff_reg <= {target[23], target} - {pos_reg[23], pos_reg};
            end
            OP_SET_OMEGA: omega_reg <= rnd16[26:0];
            OP_SET_W2:    w2_reg    <= rnd16[37:0];
            OP_SET_ZW:    zw_reg    <= rnd12[30:0];
            OP_ACC_LOAD:  accum_reg <= prod64;
            OP_ACC_ADD19: accum_reg <= accum_reg + (prod64 <<< 19);
            OP_ACC_SUB1:  accum_reg <= accum_reg - (prod64 <<< 1);
            OP_SET_ACC:   acccl_reg <= acc_clamped;
            OP_SET_VEL:   vnew_reg  <= vel_clamped;
            OP_SET_POS: begin
                pnew_reg <= pos_clamped;
                if (pos_clipped) begin
                    vnew_reg <= '0;
                end
            end
            OP_DIV_START: dneg_reg <= vdiff[24];
            default: ;
        endcase
    end

    assign status.is_step  = (act_reg == ACT_STEP);
    assign status.step_go  = flag_reg && cfg_valid && (dt_reg != '0);
    assign status.div_busy = div_busy;

    assign out_item.ref_position     = pos_reg;
    assign out_item.ref_velocity     = vel_reg;
    assign out_item.ref_acceleration = accel_reg;
    assign out_item.is_initialized   = flag_reg;

endmodule

[sv/sops_ctrl.sv]
// sequencer that steps the datapath through one item and owns the handshakes
module sops_ctrl
    import sops_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECIDE,
        ST_OM_M, ST_OM_S, ST_W2_M, ST_W2_S, ST_ZW_M, ST_ZW_S,
        ST_R1_M, ST_R1_A, ST_R2_M, ST_R2_A, ST_R3_M, ST_R3_A, ST_ACC_S,
        ST_VEL_M, ST_VEL_S, ST_POS_M, ST_POS_S,
        ST_DIV_GO, ST_DIV_WAIT,
        ST_C_RESET, ST_C_STEP, ST_C_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   slot_free;
    logic   commit;

    assign slot_free = !mvalid_reg || m_ready;
    assign commit    = slot_free &&
                       (state_reg == ST_C_RESET || state_reg == ST_C_STEP ||
                        state_reg == ST_C_HOLD);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!status.is_step) begin
                    state_next = ST_C_RESET;
                end else if (status.step_go) begin
                    state_next = ST_OM_M;
                end else begin
                    state_next = ST_C_HOLD;
                end
            end
            ST_OM_M:  begin cmd.op = OP_MUL_OMEGA; state_next = ST_OM_S;  end
            ST_OM_S:  begin cmd.op = OP_SET_OMEGA; state_next = ST_W2_M;  end
            ST_W2_M:  begin cmd.op = OP_MUL_W2;    state_next = ST_W2_S;  end
            ST_W2_S:  begin cmd.op = OP_SET_W2;    state_next = ST_ZW_M;  end
            ST_ZW_M:  begin cmd.op = OP_MUL_ZW;    state_next = ST_ZW_S;  end
            ST_ZW_S:  begin cmd.op = OP_SET_ZW;    state_next = ST_R1_M;  end
            ST_R1_M:  begin cmd.op = OP_MUL_WLO;   state_next = ST_R1_A;  end
            ST_R1_A:  begin cmd.op = OP_ACC_LOAD;  state_next = ST_R2_M;  end
            ST_R2_M:  begin cmd.op = OP_MUL_WHI;   state_next = ST_R2_A;  end
            ST_R2_A:  begin cmd.op = OP_ACC_ADD19; state_next = ST_R3_M;  end
            ST_R3_M:  begin cmd.op = OP_MUL_ZV;    state_next = ST_R3_A;  end
            ST_R3_A:  begin cmd.op = OP_ACC_SUB1;  state_next = ST_ACC_S; end
            ST_ACC_S: begin cmd.op = OP_SET_ACC;   state_next = ST_VEL_M; end
            ST_VEL_M: begin cmd.op = OP_MUL_DTA;   state_next = ST_VEL_S; end
            ST_VEL_S: begin cmd.op = OP_SET_VEL;   state_next = ST_POS_M; end
            ST_POS_M: begin cmd.op = OP_MUL_DTV;   state_next = ST_POS_S; end
            ST_POS_S: begin cmd.op = OP_SET_POS;   state_next = ST_DIV_GO; end
            ST_DIV_GO: begin
                cmd.op     = OP_DIV_START;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_C_STEP;
                end
            end
            // held state is the output register, so wait until it is taken
            ST_C_RESET: begin
                if (slot_free) begin
                    cmd.op     = OP_COMMIT_RESET;
                    state_next = ST_IDLE;
                end
            end
            ST_C_STEP: begin
                if (slot_free) begin
                    cmd.op     = OP_COMMIT_STEP;
                    state_next = ST_IDLE;
                end
            end
            ST_C_HOLD: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (commit) begin
            mvalid_next = 1'b1;
        end else if (m_ready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;

endmodule

[sv/sops_checker.sv]
// port-level checks for the position shaper, bound to the top level
module sops_checker
    import sops_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input sops_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input sops_out_t m_data
);

    // a stalled result item holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result item changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in work");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid just after reset");

    // an uninitialised shaper only ever reports a zero state
    a_uninit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_initialized |->
            m_data.ref_position == '0 && m_data.ref_velocity == '0 &&
            m_data.ref_acceleration == '0)
        else $error("non-zero state reported while uninitialised");

endmodule

bind second_order_position_shaper sops_checker u_sops_checker (.*);

[tb/sv/sops_checker.sv]
// checker for the position shaper: predicts each result item from the accepted input items
module sops_scoreboard
    import sops_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  sops_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  sops_out_t m_data,
    input  logic      cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_wdata,
    output int        fail_count,
    output int        pending_count
);

    longint nat_freq, damping, vel_lim, acc_lim, pos_lo, pos_hi;
    longint pos_q, vel_q, acc_q;
    bit     init_q;
    sops_out_t shaped_q[$];

    function automatic longint round_shift(longint x, int s);
        longint y;
        y = x + (longint'(1) << (s - 1));
        return y >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit cfg_ok();
        return nat_freq != 0 && damping != 0 && vel_lim != 0 && acc_lim != 0 && pos_lo < pos_hi;
    endfunction

    task automatic shape_item(sops_in_t it);
        longint pin, vin, dt, omega, w2, zw, tgt, req, acc, vold, vnew, cand, pnew, aout;
        sops_out_t r;
        pin = longint'(it.position_in);
        vin = longint'(it.velocity_in);
        dt  = longint'({1'b0, it.time_step});
        if (it.action == ACT_RESET) begin
            if (!cfg_ok() || pin < pos_lo || pin > pos_hi || vin > vel_lim || vin < -vel_lim) begin
                pos_q = 0; vel_q = 0; acc_q = 0; init_q = 0;
            end else begin
                pos_q = pin; vel_q = vin; acc_q = 0; init_q = 1;
            end
        end else if (init_q && cfg_ok() && dt != 0) begin
            omega = round_shift(nat_freq * longint'(TWO_PI_Q24), 16);
            w2    = round_shift(omega * omega, 16);
            zw    = round_shift(damping * omega, 12);
            tgt   = clip(pin, pos_lo, pos_hi);
            req   = round_shift(w2 * (tgt - pos_q) - 2 * zw * vel_q, 16);
            acc   = clip(req, -acc_lim, acc_lim);
            vold  = vel_q;
            vnew  = clip(vold + round_shift(dt * acc, TIME_FRAC_BITS), -vel_lim, vel_lim);
            cand  = pos_q + round_shift(dt * vnew, TIME_FRAC_BITS);
            pnew  = clip(cand, pos_lo, pos_hi);
            // position hit a limit so the motion stops
            if (pnew != cand) vnew = 0;
            aout  = ((vnew - vold) * (longint'(1) << TIME_FRAC_BITS)) / dt;
            pos_q = pnew;
            vel_q = vnew;
            acc_q = clip(aout, -64'sd2147483648, 64'sd2147483647);
        end
        r.ref_position     = pos_q[23:0];
        r.ref_velocity     = vel_q[23:0];
        r.ref_acceleration = acc_q[31:0];
        r.is_initialized   = init_q;
        shaped_q.push_back(r);
    endtask

    assign pending_count = shaped_q.size();

    always @(posedge aclk) begin
        sops_out_t e;
        if (!aresetn) begin
            nat_freq = 256; damping = 4096; vel_lim = 65536; acc_lim = 655360;
            pos_lo = -65536; pos_hi = 65536;
            pos_q = 0; vel_q = 0; acc_q = 0; init_q = 0;
            shaped_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NAT_FREQ:  nat_freq = longint'(cfg_wdata[15:0]);
                    CFG_DAMPING:   damping  = longint'(cfg_wdata[15:0]);
                    CFG_VEL_LIMIT: vel_lim  = longint'(cfg_wdata[22:0]);
                    CFG_ACC_LIMIT: acc_lim  = longint'(cfg_wdata[30:0]);
                    CFG_POS_FLOOR: pos_lo   = longint'($signed(cfg_wdata[23:0]));
                    CFG_POS_CEIL:  pos_hi   = longint'($signed(cfg_wdata[23:0]));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (shaped_q.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    e = shaped_q.pop_front();
                    if (e !== m_data) begin
                        if (e.ref_position !== m_data.ref_position)
                            $error("ref_position exp %0d got %0d", e.ref_position,
                                   m_data.ref_position);
                        if (e.ref_velocity !== m_data.ref_velocity)
                            $error("ref_velocity exp %0d got %0d", e.ref_velocity,
                                   m_data.ref_velocity);
                        if (e.ref_acceleration !== m_data.ref_acceleration)
                            $error("ref_acceleration exp %0d got %0d", e.ref_acceleration,
                                   m_data.ref_acceleration);
                        if (e.is_initialized !== m_data.is_initialized)
                            $error("is_initialized exp %0d got %0d", e.is_initialized,
                                   m_data.is_initialized);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) shape_item(s_data);
        end
    end

endmodule

[tb/sv/tb.sv]
// testbench top: stimulus, configuration phases and verdict for the position shaper
module tb;
    import sops_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    sops_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    sops_out_t   m_data;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_wdata = '0;
    int          fail_count, pending_count;
    int          send_idle = 0, recv_idle = 0;

    second_order_position_shaper u_top (.*);
    sops_scoreboard u_chk (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("tb: errors");
        $finish;
    end

    // receiver stall
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // valid stays up after the accept until the next item or an idle cycle replaces it
    task automatic send_item(logic act, logic [23:0] p, logic [23:0] v, logic [23:0] dt);
        cfg_we <= 0;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= '{act, p, v, dt};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= val[30:0];
        @(posedge aclk);
    endtask

    task automatic random_config(int kind);
        if (kind == 0) begin
            write_reg(CFG_NAT_FREQ, 1); write_reg(CFG_DAMPING, 1);
            write_reg(CFG_VEL_LIMIT, 1); write_reg(CFG_ACC_LIMIT, 1);
            write_reg(CFG_POS_FLOOR, 32'h800000); write_reg(CFG_POS_CEIL, 32'h7fffff);
        end else if (kind == 1) begin
            write_reg(CFG_NAT_FREQ, 65535); write_reg(CFG_DAMPING, 65535);
            write_reg(CFG_VEL_LIMIT, 8388607); write_reg(CFG_ACC_LIMIT, 32'h7fffffff);
            write_reg(CFG_POS_FLOOR, 32'h800000); write_reg(CFG_POS_CEIL, 32'h7fffff);
        end else begin
            write_reg(CFG_NAT_FREQ, $urandom_range(65535, 1));
            write_reg(CFG_DAMPING, $urandom_range(65535, 1));
            write_reg(CFG_VEL_LIMIT, $urandom_range(8388607, 1));
            write_reg(CFG_ACC_LIMIT, $urandom_range(31'h7fffffff, 1));
            write_reg(CFG_POS_FLOOR, {8'd0, 24'($signed(-$urandom_range(8388608, 1)))});
            write_reg(CFG_POS_CEIL, $urandom_range(8388607));
        end
    endtask

    task automatic random_run(int n);
        logic [23:0] p, v, dt;
        for (int i = 0; i < n; i++) begin
            p = 24'($urandom); v = 24'($urandom);
            dt = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(65535));
            if ($urandom_range(19) == 0) dt = '0;
            if ($urandom_range(2) == 0) v = 24'($signed(v) >>> $urandom_range(23));
            if ($urandom_range(1)) p = 24'($signed(p) >>> $urandom_range(23));
            // mostly steps after a reset so the filter actually runs
            send_item(($urandom_range(24) == 0) ? ACT_RESET : ACT_STEP, p, v, dt);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: default registers
        send_item(ACT_STEP, 24'd100, '0, 24'd1000);
        send_item(ACT_RESET, 24'h7fffff, '0, '0);
        send_item(ACT_RESET, '0, 24'h800000, '0);
        send_item(ACT_RESET, 24'd100, 24'd5, 24'hffffff);
        send_item(ACT_STEP, 24'h7fffff, '0, 24'hffffff);
        send_item(ACT_STEP, 24'h800000, '0, 24'd1);
        send_item(ACT_STEP, 24'd500, '0, '0);
        send_item(ACT_RESET, 24'd65536, 24'd65536, '0);
        send_item(ACT_STEP, 24'd65536, '0, 24'd2000000);
        send_item(ACT_RESET, 24'hff0000, 24'hff0000, '0);
        send_item(ACT_STEP, 24'h800000, '0, 24'hffffff);
        drain();
        // invalid configuration: floor not below ceiling, bad index ignored
        write_reg(CFG_POS_FLOOR, 32'd65536);
        write_reg(3'd7, 32'h7fffffff);
        send_item(ACT_STEP, '0, '0, 24'd100);
        send_item(ACT_RESET, 24'd65536, '0, '0);
        drain();
        random_config(1);
        send_item(ACT_RESET, 24'h7fffff, 24'h7fffff, '0);
        send_item(ACT_STEP, 24'h800000, 24'h7fffff, 24'hffffff);
        send_item(ACT_STEP, 24'h800000, '0, 24'hffffff);
        send_item(ACT_RESET, 24'h800000, 24'h800001, '0);
        send_item(ACT_STEP, 24'h7fffff, '0, 24'h800000);
        drain();
        random_config(0);
        send_item(ACT_RESET, 24'd3, 24'hffffff, '0);
        send_item(ACT_STEP, 24'h7fffff, '0, 24'hffffff);
        drain();
        for (int ph = 0; ph < 11; ph++) begin
            if (ph < 4) begin send_idle = 17; recv_idle = 85; end
            else if (ph < 8) begin send_idle = 85; recv_idle = 17; end
            else begin send_idle = 0; recv_idle = 0; end
            random_config(ph == 3 ? 1 : (ph == 6 ? 0 : 2));
            send_item(ACT_RESET, 24'($urandom_range(100)), 24'($urandom_range(15)), '0);
            random_run(75);
            // hold off until the pipeline is empty
            s_valid <= 0;
            while (pending_count != 0) @(posedge aclk);
            random_run(75);
            drain();
        end
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

[sim.f]
sv/sops_pkg.sv
sv/sops_div.sv
sv/sops_dp.sv
sv/sops_ctrl.sv
sv/second_order_position_shaper.sv
sv/sops_checker.sv
tb/sv/sops_checker.sv
tb/sv/tb.sv
